### src/ddsm_pkg.sv
`default_nettype none

package ddsm_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WHEEL_SPACING        = 3'd0,
    CFG_MIN_SPEED            = 3'd1,
    CFG_MAX_SPEED            = 3'd2,
    CFG_TURN_OFFSET_MOVING   = 3'd3,
    CFG_TURN_OFFSET_IN_PLACE = 3'd4,
    CFG_TURN_SCALE_MOVING    = 3'd5,
    CFG_TURN_SCALE_IN_PLACE  = 3'd6
  } cfg_idx_t;

  localparam logic OP_COMMAND  = 1'b0;
  localparam logic OP_ODOMETRY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mul_en;
    logic mul_first;
    logic add_turn;
    logic sum_wheels;
    logic shape_wheels;
    logic lin_step;
    logic turn_step;
    logic load_out;
    logic last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op;
    logic boosting;
    logic targets_zero;
    logic lin_stall;
    logic turn_stall;
  } status_t;

endpackage

`default_nettype wire

### src/ddsm_chan_if.sv
`default_nettype none

interface ddsm_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] linear_value;
  logic signed [15:0] angular_value;

  modport source (output valid, operation, linear_value, angular_value, input ready);
  modport sink (input valid, operation, linear_value, angular_value, output ready);
endinterface

interface ddsm_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] left_code;
  logic signed [7:0] right_code;
  logic              last;

  modport source (output valid, left_code, right_code, last, input ready);
  modport sink (input valid, left_code, right_code, last, output ready);
endinterface

`default_nettype wire

### src/diff_drive_speed_mixer_stall_boost_top.sv
// Differential-drive speed mixer with stall boost.
//
// The in_chan channel carries one beat per item: operation 0 is a velocity
// command (linear, angular), operation 1 is an odometry report. The out_chan
// channel carries motor-code beats (left_code, right_code, last); last marks
// the final beat that an item causes. An item causes zero, one or two beats.
// Configuration is written via cfg_we / cfg_addr / cfg_wdata; the user must
// do so only while idle, which the block does not check; address 7 is ignored.
//
// Items are processed one at a time. A mixed command goes through decode, two
// passes through a single shared 26x17 multiplier with a rounding add between
// them, sum, shape and load into the result register, and the input reopens
// in the cycle after the load. A report that boosts loads its first beat after
// decode and one step, and a second beat, if any, after a second step. A
// command that is only saved, or a report that causes nothing, frees the input
// after decode. The block takes the next item while a beat waits in the output
// register and stalls only when a new beat finds it still full.
// Synchronous reset restores register defaults, zeroes speeds, targets and the
// saved command, and drops boost mode.

`default_nettype none

module diff_drive_speed_mixer_stall_boost_top import ddsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ddsm_in_if.sink               in_chan,
  ddsm_out_if.source            out_chan
);

  cmd_t              cmd;
  status_t           status;
  logic              out_valid;
  logic              in_ready;
  logic signed [7:0] left_code;
  logic signed [7:0] right_code;
  logic              last;

  // The controller sequences each item and owns both handshakes.
  ddsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds configuration, wheel state, the shared multiplier
  // and the result register.
  ddsm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_operation (in_chan.operation),
    .in_linear    (in_chan.linear_value),
    .in_angular   (in_chan.angular_value),
    .cmd          (cmd),
    .status       (status),
    .left_code    (left_code),
    .right_code   (right_code),
    .last         (last)
  );

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid;
  assign out_chan.left_code  = left_code;
  assign out_chan.right_code = right_code;
  assign out_chan.last       = last;

endmodule

`default_nettype wire

### src/ddsm_ctrl.sv
`default_nettype none

module ddsm_ctrl import ddsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    IDLE,
    DECIDE,
    MUL_SCALE,
    ADD_TURN,
    MUL_SPACING,
    SUM_WHEELS,
    SHAPE_WHEELS,
    LIN_STEP,
    TURN_STEP,
    EMIT
  } state_t;

  state_t state;
  logic   more;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == IDLE);

  always_comb begin
    cmd              = '0;
    cmd.accept       = (state == IDLE) && in_valid;
    cmd.mul_en       = (state == MUL_SCALE) || (state == MUL_SPACING);
    cmd.mul_first    = (state == MUL_SCALE);
    cmd.add_turn     = (state == ADD_TURN);
    cmd.sum_wheels   = (state == SUM_WHEELS);
    cmd.shape_wheels = (state == SHAPE_WHEELS);
    cmd.lin_step     = (state == LIN_STEP);
    cmd.turn_step    = (state == TURN_STEP);
    cmd.load_out     = (state == EMIT) && out_free;
    cmd.last         = !more;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      more      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= DECIDE;
          end
        end
        DECIDE: begin
          more <= (status.op != OP_COMMAND) && !status.targets_zero
                  && status.lin_stall && status.turn_stall;
          if (status.op == OP_COMMAND) begin
            state <= status.boosting ? IDLE : MUL_SCALE;
          end else if (status.targets_zero) begin
            state <= IDLE;
          end else if (status.lin_stall) begin
            state <= LIN_STEP;
          end else if (status.turn_stall) begin
            state <= TURN_STEP;
          end else if (status.boosting) begin
            state <= MUL_SCALE;
          end else begin
            state <= IDLE;
          end
        end
        MUL_SCALE:    state <= ADD_TURN;
        ADD_TURN:     state <= MUL_SPACING;
        MUL_SPACING:  state <= SUM_WHEELS;
        SUM_WHEELS:   state <= SHAPE_WHEELS;
        SHAPE_WHEELS: state <= EMIT;
        LIN_STEP:     state <= EMIT;
        TURN_STEP:    state <= EMIT;
        EMIT: begin
          if (out_free) begin
            more  <= 1'b0;
            state <= more ? TURN_STEP : IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/ddsm_datapath.sv
`default_nettype none

module ddsm_datapath import ddsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_operation,
  input  logic signed [15:0]    in_linear,
  input  logic signed [15:0]    in_angular,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic signed [7:0]     left_code,
  output logic signed [7:0]     right_code,
  output logic                  last
);

  // Configuration registers.
  logic [15:0]        wheel_spacing;
  logic [15:0]        min_speed;
  logic signed [15:0] max_speed;
  logic signed [15:0] turn_offset_moving;
  logic signed [15:0] turn_offset_in_place;
  logic [15:0]        turn_scale_moving;
  logic [15:0]        turn_scale_in_place;

  // Block state.
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic signed [15:0] left_target;
  logic signed [15:0] right_target;
  logic               boosting;
  logic signed [15:0] saved_linear;
  logic signed [15:0] saved_angular;

  // Latched item flags.
  logic op;
  logic lin_zero;
  logic ang_zero;

  // Working registers.
  logic signed [42:0] prod;
  logic signed [25:0] turn_adj;
  logic signed [39:0] right_wide;
  logic signed [39:0] left_wide;

  logic signed [25:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [42:0] prod_r8;
  logic signed [42:0] prod_r9;
  logic signed [15:0] offset_sel;
  logic signed [25:0] offset_term;
  logic signed [39:0] lin_wide;
  logic signed [16:0] lt17;
  logic signed [16:0] rt17;
  logic signed [16:0] left_mag;
  logic signed [16:0] right_mag;

  function automatic logic signed [15:0] cap16(input logic signed [15:0] v,
                                               input logic signed [15:0] cap);
    return (v < cap) ? v : cap;
  endfunction

  // Move a speed one step away from zero, then cap it.
  function automatic logic signed [15:0] step_up(input logic signed [15:0] v,
                                                 input logic signed [15:0] cap);
    logic signed [16:0] t;
    logic signed [16:0] cap_w;
    t     = 17'(v);
    cap_w = 17'(cap);
    if (v > 16'sd0) begin
      t = t + 17'sd256;
    end else if (v < 16'sd0) begin
      t = t - 17'sd256;
    end
    if (t > cap_w) begin
      t = cap_w;
    end
    if (t < -17'sd32768) begin
      t = -17'sd32768;
    end
    return t[15:0];
  endfunction

  // Cap above, push a nonzero value up to the minimum magnitude, saturate.
  function automatic logic signed [15:0] shape_wheel(input logic signed [39:0] x,
                                                     input logic signed [15:0] cap,
                                                     input logic [15:0] floor_mag);
    logic signed [39:0] c;
    logic signed [39:0] mag;
    logic signed [39:0] res;
    c = (x < 40'(cap)) ? x : 40'(cap);
    mag = c[39] ? -c : c;
    if (mag < $signed({24'd0, floor_mag})) begin
      mag = $signed({24'd0, floor_mag});
    end
    res = c[39] ? -mag : mag;
    if (c == 40'sd0) begin
      res = 40'sd0;
    end
    if (res > 40'sd32767) begin
      res = 40'sd32767;
    end else if (res < -40'sd32768) begin
      res = -40'sd32768;
    end
    return res[15:0];
  endfunction

  // 28.125*v + 10*sgn(v), rounded half away from zero, saturated to a byte.
  function automatic logic signed [7:0] motor_code(input logic signed [15:0] x);
    logic signed [24:0] t;
    logic signed [24:0] r;
    t = 25'(x) * 25'sd225;
    if (x > 16'sd0) begin
      t = t + 25'sd20480;
    end else if (x < 16'sd0) begin
      t = t - 25'sd20480;
    end
    r = (t + 25'sd1024 - (t[24] ? 25'sd1 : 25'sd0)) >>> 11;
    if (r > 25'sd127) begin
      r = 25'sd127;
    end else if (r < -25'sd128) begin
      r = -25'sd128;
    end
    return r[7:0];
  endfunction

  // Shared multiplier operands: turn gain first, wheel spacing second.
  always_comb begin
    if (cmd.mul_first) begin
      mul_a = 26'(saved_angular);
      mul_b = $signed({1'b0,
        (saved_linear == 16'sd0) ? turn_scale_in_place : turn_scale_moving});
    end else begin
      mul_a = turn_adj;
      mul_b = $signed({1'b0, wheel_spacing});
    end
  end

  // Rounded shifts, half away from zero.
  assign prod_r8 = (prod + 43'sd128 - (prod[42] ? 43'sd1 : 43'sd0)) >>> 8;
  assign prod_r9 = (prod + 43'sd256 - (prod[42] ? 43'sd1 : 43'sd0)) >>> 9;

  always_comb begin
    offset_sel = (saved_linear == 16'sd0) ? turn_offset_in_place : turn_offset_moving;
    if (saved_angular > 16'sd0) begin
      offset_term = 26'(offset_sel);
    end else if (saved_angular < 16'sd0) begin
      offset_term = -26'(offset_sel);
    end else begin
      offset_term = 26'sd0;
    end
  end

  assign lin_wide = 40'(saved_linear);

  assign lt17      = 17'(left_target);
  assign rt17      = 17'(right_target);
  assign left_mag  = lt17[16] ? -lt17 : lt17;
  assign right_mag = rt17[16] ? -rt17 : rt17;

  always_comb begin
    status              = '0;
    status.op           = op;
    status.boosting     = boosting;
    status.targets_zero = (left_target == 16'sd0) && (right_target == 16'sd0);
    status.lin_stall    = lin_zero && (lt17 != -rt17)
                          && (left_target != 16'sd0) && (right_target != 16'sd0);
    status.turn_stall   = ang_zero && (left_target != right_target);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_spacing        <= 16'd65;
      min_speed            <= 16'd640;
      max_speed            <= 16'sd768;
      turn_offset_moving   <= 16'sd0;
      turn_offset_in_place <= 16'sd0;
      turn_scale_moving    <= 16'd256;
      turn_scale_in_place  <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_WHEEL_SPACING:        wheel_spacing        <= cfg_wdata;
        CFG_MIN_SPEED:            min_speed            <= cfg_wdata;
        CFG_MAX_SPEED:            max_speed            <= $signed(cfg_wdata);
        CFG_TURN_OFFSET_MOVING:   turn_offset_moving   <= $signed(cfg_wdata);
        CFG_TURN_OFFSET_IN_PLACE: turn_offset_in_place <= $signed(cfg_wdata);
        CFG_TURN_SCALE_MOVING:    turn_scale_moving    <= cfg_wdata;
        CFG_TURN_SCALE_IN_PLACE:  turn_scale_in_place  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Speed, target and command state.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_speed    <= 16'sd0;
      right_speed   <= 16'sd0;
      left_target   <= 16'sd0;
      right_target  <= 16'sd0;
      boosting      <= 1'b0;
      saved_linear  <= 16'sd0;
      saved_angular <= 16'sd0;
    end else begin
      if (cmd.accept && (in_operation == OP_COMMAND)) begin
        saved_linear  <= in_linear;
        saved_angular <= in_angular;
      end
      if (cmd.shape_wheels) begin
        left_speed   <= shape_wheel(left_wide, max_speed, min_speed);
        right_speed  <= shape_wheel(right_wide, max_speed, min_speed);
        left_target  <= shape_wheel(left_wide, max_speed, min_speed);
        right_target <= shape_wheel(right_wide, max_speed, min_speed);
        boosting     <= 1'b0;
      end
      if (cmd.lin_step) begin
        left_speed  <= step_up(left_speed, max_speed);
        right_speed <= step_up(right_speed, max_speed);
        boosting    <= 1'b1;
      end
      if (cmd.turn_step) begin
        if (left_mag > right_mag) begin
          left_speed  <= step_up(left_speed, max_speed);
          right_speed <= cap16(right_speed, max_speed);
        end else begin
          left_speed  <= cap16(left_speed, max_speed);
          right_speed <= step_up(right_speed, max_speed);
        end
        boosting <= 1'b1;
      end
    end
  end

  // Item flags, arithmetic pipeline and result payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op       <= in_operation;
      lin_zero <= (in_linear == 16'sd0);
      ang_zero <= (in_angular == 16'sd0);
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.add_turn) begin
      turn_adj <= prod_r8[25:0] + offset_term;
    end
    if (cmd.sum_wheels) begin
      right_wide <= lin_wide + prod_r9[39:0];
      left_wide  <= (lin_wide <<< 1) - (lin_wide + prod_r9[39:0]);
    end
    if (cmd.load_out) begin
      left_code  <= motor_code(left_speed);
      right_code <= motor_code(right_speed);
      last       <= cmd.last;
    end
  end

endmodule

`default_nettype wire

### test/diff_drive_speed_mixer_stall_boost_top_tb.sv
`timescale 1ns / 100ps

// One pair of motor codes as it leaves the block.
typedef struct packed {
  logic signed [7:0] left_code;
  logic signed [7:0] right_code;
  logic              last;
} wheel_codes_t;

// Tracks registers and wheel state, predicts motor codes, checks result beats.
class wheel_code_scoreboard;
  logic        [15:0] spacing, min_mag, gain_move, gain_spin;
  logic signed [15:0] cap, off_move, off_spin;
  logic signed [15:0] spd_l, spd_r, tgt_l, tgt_r, held_lin, held_ang;
  bit                 in_boost;
  wheel_codes_t       pending_codes[$];
  int                 errors, beats, commands, reports, boost_beats;

  function new();
    spacing   = 16'd65;
    min_mag   = 16'd640;
    cap       = 16'sd768;
    off_move  = 16'sd0;
    off_spin  = 16'sd0;
    gain_move = 16'd256;
    gain_spin = 16'd256;
    spd_l = 0; spd_r = 0; tgt_l = 0; tgt_r = 0;
    held_lin = 0; held_ang = 0;
    in_boost = 1'b0;
    errors = 0; beats = 0; commands = 0; reports = 0; boost_beats = 0;
  endfunction

  function void set_reg(logic [ddsm_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] val);
    case (idx)
      ddsm_pkg::CFG_WHEEL_SPACING:        spacing   = val;
      ddsm_pkg::CFG_MIN_SPEED:            min_mag   = val;
      ddsm_pkg::CFG_MAX_SPEED:            cap       = val;
      ddsm_pkg::CFG_TURN_OFFSET_MOVING:   off_move  = val;
      ddsm_pkg::CFG_TURN_OFFSET_IN_PLACE: off_spin  = val;
      ddsm_pkg::CFG_TURN_SCALE_MOVING:    gain_move = val;
      ddsm_pkg::CFG_TURN_SCALE_IN_PLACE:  gain_spin = val;
      default: ;
    endcase
  endfunction

  function longint sgn(longint v);
    return (v > 0) ? 64'sd1 : ((v < 0) ? -64'sd1 : 64'sd0);
  endfunction

  // Divide by 2^k, rounding half away from zero.
  function longint round_shift(longint x, int k);
    longint half, div;
    half = longint'(1) << (k - 1);
    div  = longint'(1) << k;
    if (x >= 0) return (x + half) / div;
    return -((-x + half) / div);
  endfunction

  function logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function longint cap_speed(longint v);
    longint c;
    c = cap;
    return (v < c) ? v : c;
  endfunction

  function longint shape_wheel(longint v);
    longint m, mag;
    m = min_mag;
    v = cap_speed(v);
    if (v != 0) begin
      mag = (v < 0) ? -v : v;
      if (mag < m) mag = m;
      v = (v < 0) ? -mag : mag;
    end
    return v;
  endfunction

  function logic signed [7:0] code_of(logic signed [15:0] s);
    longint v, c;
    v = s;
    c = round_shift(225 * v + 20480 * sgn(v), 11);
    if (c > 127) c = 127;
    if (c < -128) c = -128;
    return c[7:0];
  endfunction

  function logic signed [15:0] step_up(logic signed [15:0] s);
    longint v;
    v = s;
    return sat16(cap_speed(v + 256 * sgn(v)));
  endfunction

  function void mix(longint v, longint w);
    longint g, o, d, r, l;
    d = spacing;
    if (w != 0) begin
      if (v == 0) begin
        g = gain_spin;
        o = off_spin;
      end else begin
        g = gain_move;
        o = off_move;
      end
      w = round_shift(w * g, 8) + o * sgn(w);
    end
    r = v + round_shift(w * d, 9);
    l = 2 * v - r;
    spd_l = sat16(shape_wheel(l));
    spd_r = sat16(shape_wheel(r));
    tgt_l = spd_l;
    tgt_r = spd_r;
    in_boost = 1'b0;
  endfunction

  function void push_codes(bit last);
    wheel_codes_t c;
    c.left_code  = code_of(spd_l);
    c.right_code = code_of(spd_r);
    c.last       = last;
    pending_codes.push_back(c);
  endfunction

  // Returns 1 when an odometry report finds both targets at zero, so the block ignores it.
  function bit note_item(logic op, logic signed [15:0] lin, logic signed [15:0] ang);
    longint lt, rt, al, ar;
    bit lin_stall, turn_stall;
    if (op == ddsm_pkg::OP_COMMAND) begin
      commands++;
      held_lin = lin;
      held_ang = ang;
      if (!in_boost) begin
        mix(lin, ang);
        push_codes(1'b1);
      end
      return 1'b0;
    end
    lt = tgt_l;
    rt = tgt_r;
    if (lt == 0 && rt == 0) return 1'b1;
    reports++;
    lin_stall  = (lin == 0) && (lt != -rt) && (lt != 0) && (rt != 0);
    turn_stall = (ang == 0) && (lt != rt);
    if (lin_stall) begin
      in_boost = 1'b1;
      spd_l = step_up(spd_l);
      spd_r = step_up(spd_r);
      push_codes(!turn_stall);
      boost_beats++;
    end
    if (turn_stall) begin
      al = (lt < 0) ? -lt : lt;
      ar = (rt < 0) ? -rt : rt;
      in_boost = 1'b1;
      if (al > ar) spd_l = step_up(spd_l);
      else spd_r = step_up(spd_r);
      spd_r = sat16(cap_speed(spd_r));
      spd_l = sat16(cap_speed(spd_l));
      push_codes(1'b1);
      boost_beats++;
    end
    if (!lin_stall && !turn_stall && in_boost) begin
      mix(held_lin, held_ang);
      push_codes(1'b1);
    end
    return 1'b0;
  endfunction

  task report(string what);
    errors++;
    if (errors <= 40) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task check_beat(logic signed [7:0] l, logic signed [7:0] r, logic last);
    wheel_codes_t want;
    beats++;
    if (pending_codes.size() == 0) begin
      report($sformatf("unexpected beat left %0d right %0d last %0b", l, r, last));
      return;
    end
    want = pending_codes.pop_front();
    if (l !== want.left_code)
      report($sformatf("left_code %0d, expected %0d", l, want.left_code));
    if (r !== want.right_code)
      report($sformatf("right_code %0d, expected %0d", r, want.right_code));
    if (last !== want.last)
      report($sformatf("last %0b, expected %0b", last, want.last));
  endtask

  task report_leftovers();
    while (pending_codes.size() != 0) begin
      report($sformatf("beat never arrived: left %0d right %0d",
                       pending_codes[0].left_code, pending_codes[0].right_code));
      void'(pending_codes.pop_front());
    end
  endtask
endclass

module diff_drive_speed_mixer_stall_boost_top_tb;
  import ddsm_pkg::*;

  // Index 7 has no register behind it; writes there must change nothing.
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SPARE = 3'd7;
  // This covers the longest item, such as a command that is mixed.
  localparam int SETTLE_CYCLES   = 16;
  localparam int ITEMS_PER_PHASE = 215;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_BURSTY} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    settings_used = 1;

  ddsm_in_if  in_chan ();
  ddsm_out_if out_chan ();

  wheel_code_scoreboard board = new();

  diff_drive_speed_mixer_stall_boost_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Field values lean toward zero, the extremes and small speeds, since those
  // are where the shaping, capping and stall logic change behavior. A fifth
  // are fully random so every bit of the field toggles.
  function automatic logic signed [15:0] pick_q88();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: return 16'sd0;
      5:             return 16'sh7fff;
      6:             return 16'sh8000;
      7:             return 16'sd1;
      8:             return -16'sd1;
      9, 10, 11, 12, 13, 14, 15:
        return 16'($urandom_range(0, 2048)) - 16'sd1024;
      default:       return 16'($urandom);
    endcase
  endfunction

  // Present one item and hold it until the block takes it. Ready is sampled
  // at the rising edge, before the block updates it, so acceptance is exactly
  // the edge at which valid and ready were both high.
  task automatic send_item(input logic op, input logic signed [15:0] lin,
                           input logic signed [15:0] ang, output bit ignored);
    in_chan.valid         <= 1'b1;
    in_chan.operation     <= op;
    in_chan.linear_value  <= lin;
    in_chan.angular_value <= ang;
    do @(posedge clk); while (!in_chan.ready);
    ignored = board.note_item(op, lin, ang);
  endtask

  // Drop valid and wait for every expected beat, then give the block time to
  // finish any item that causes no beat at all.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (board.pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  // Writes the full register set, plus a junk write to the unused index.
  task automatic write_setting(input logic [15:0] spacing, input logic [15:0] min_mag,
                               input logic [15:0] cap, input logic [15:0] off_move,
                               input logic [15:0] off_spin, input logic [15:0] gain_move,
                               input logic [15:0] gain_spin);
    write_reg(CFG_WHEEL_SPACING, spacing);
    write_reg(CFG_MIN_SPEED, min_mag);
    write_reg(CFG_MAX_SPEED, cap);
    write_reg(CFG_TURN_OFFSET_MOVING, off_move);
    write_reg(CFG_TURN_OFFSET_IN_PLACE, off_spin);
    write_reg(CFG_TURN_SCALE_MOVING, gain_move);
    write_reg(CFG_TURN_SCALE_IN_PLACE, gain_spin);
    write_reg(CFG_IDX_SPARE, 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Hand-picked items at reset defaults. They walk through these branches:
  // an odometry report with no targets, commands at both extremes and in
  // place, a linear stall, a command saved during boost, a resume that
  // replays the saved command, a second linear stall with a single beat,
  // and a turning stall.
  task automatic run_directed();
    bit ignored;
    send_item(OP_ODOMETRY, 16'sd0, 16'sd0, ignored);        // targets zero: ignored
    send_item(OP_COMMAND, 16'sd0, 16'sd0, ignored);         // standstill
    send_item(OP_COMMAND, 16'sh7fff, 16'sd0, ignored);      // capped forward
    send_item(OP_COMMAND, 16'sh8000, 16'sd0, ignored);      // full reverse
    send_item(OP_COMMAND, 16'sd0, 16'sh7fff, ignored);      // spin in place
    send_item(OP_COMMAND, 16'sd0, 16'sh8000, ignored);
    send_item(OP_COMMAND, 16'sd512, 16'sd0, ignored);       // pushed up to min speed
    send_item(OP_ODOMETRY, 16'sd0, 16'sd100, ignored);      // linear stall
    send_item(OP_COMMAND, 16'sd300, 16'sd40, ignored);      // saved only while boosting
    send_item(OP_ODOMETRY, 16'sd200, 16'sd0, ignored);      // motion back: replay
    send_item(OP_COMMAND, 16'sd256, 16'sd200, ignored);
    send_item(OP_ODOMETRY, 16'sd0, 16'sd0, ignored);        // linear stall again: one beat
    send_item(OP_ODOMETRY, 16'sd100, 16'sd100, ignored);    // resume
    send_item(OP_COMMAND, 16'sd0, 16'sd300, ignored);       // wheels opposed
    send_item(OP_ODOMETRY, 16'sd0, 16'sd50, ignored);       // turning, no stall
    send_item(OP_ODOMETRY, 16'sd0, 16'sd0, ignored);        // turning stall only
    send_item(OP_ODOMETRY, 16'sh8000, 16'sh8000, ignored);  // resume
    send_item(OP_COMMAND, 16'sh8000, 16'sh7fff, ignored);
    send_item(OP_ODOMETRY, 16'sh7fff, 16'sh7fff, ignored);
    send_item(OP_COMMAND, 16'sd0, 16'sd0, ignored);         // targets back to zero
    send_item(OP_ODOMETRY, 16'sd0, 16'sd0, ignored);        // ignored again
    wait_idle();
  endtask

  // Mostly well-formed traffic: a command followed by a handful of odometry
  // reports, which often show no motion so the block enters boost, and now
  // and then another command that lands while boosting. The rest is noise.
  // The sender works in bursts with random gaps, and occasionally holds off
  // entirely until the block has drained.
  task automatic run_phase(input int n_items);
    int counted, burst_left, follow_left;
    bit ignored;
    logic op;
    logic signed [15:0] lin, ang;
    counted     = 0;
    follow_left = 0;
    burst_left  = $urandom_range(1, 12);
    while (counted < n_items) begin
      if (follow_left > 0) begin
        follow_left--;
        if ($urandom_range(0, 7) == 0) begin
          op  = OP_COMMAND;
          lin = pick_q88();
          ang = pick_q88();
        end else begin
          op  = OP_ODOMETRY;
          lin = $urandom_range(0, 1) ? 16'sd0 : pick_q88();
          ang = $urandom_range(0, 1) ? 16'sd0 : pick_q88();
        end
      end else if ($urandom_range(0, 4) != 0) begin
        op          = OP_COMMAND;
        lin         = pick_q88();
        ang         = pick_q88();
        follow_left = $urandom_range(1, 6);
      end else begin
        op  = $urandom_range(0, 1) ? OP_ODOMETRY : OP_COMMAND;
        lin = 16'($urandom);
        ang = 16'($urandom);
      end
      send_item(op, lin, ang, ignored);
      if (!ignored) counted++;
      burst_left--;
      if ($urandom_range(0, 149) == 0) begin
        wait_idle();
        burst_left = $urandom_range(1, 12);
      end else if (burst_left <= 0) begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
      end
    end
    wait_idle();
  endtask

  // Receiver: the beat is checked at the edge where it is taken, and ready
  // follows a stall pattern, picked anew at random, that ranges from always
  // ready through random stalls to long blocked stretches.
  initial begin
    rx_mode_t mode;
    int mode_left;
    mode      = RX_ALWAYS;
    mode_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_chan.valid && out_chan.ready)
        board.check_beat(out_chan.left_code, out_chan.right_code, out_chan.last);
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        RX_ALWAYS: out_chan.ready <= 1'b1;
        RX_MOSTLY: out_chan.ready <= ($urandom_range(0, 3) != 0);
        RX_RARELY: out_chan.ready <= ($urandom_range(0, 3) == 0);
        default:   out_chan.ready <= ((mode_left % 40) < 4);
      endcase
    end
  end

  // Main sequence: reset, directed items at the defaults, then random traffic
  // under several register settings. Registers change only once the block
  // has gone quiet.
  initial begin
    in_chan.valid         = 1'b0;
    in_chan.operation     = OP_COMMAND;
    in_chan.linear_value  = '0;
    in_chan.angular_value = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_phase(ITEMS_PER_PHASE);

    // Typical geometry with nonzero turn offsets and gains away from unity.
    write_setting(16'd128, 16'd200, 16'd1500, 16'd30, 16'd60, 16'd300, 16'd400);
    run_phase(ITEMS_PER_PHASE);

    // Every register at its top value.
    write_setting(16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff);
    run_phase(ITEMS_PER_PHASE);

    // Every register at its bottom value; the negative cap clamps all speeds.
    write_setting(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
    run_phase(ITEMS_PER_PHASE);

    // Fully random register contents.
    write_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(ITEMS_PER_PHASE);

    // Random but realistic values, so that speeds stay mostly unsaturated.
    write_setting(16'($urandom_range(16, 512)), 16'($urandom_range(0, 1024)),
                  16'($urandom_range(256, 8000)), 16'($urandom_range(0, 400)) - 16'd200,
                  16'($urandom_range(0, 400)) - 16'd200, 16'($urandom_range(128, 512)),
                  16'($urandom_range(128, 512)));
    run_phase(ITEMS_PER_PHASE);

    board.report_leftovers();
    $display("Covered %0d commands and %0d odometry reports under %0d register settings.",
             board.commands, board.reports, settings_used);
    $display("Checked %0d result beats, %0d of them stall boosts; %0d mismatches.",
             board.beats, board.boost_beats, board.errors);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Timed out with %0d beats still expected.", board.pending_codes.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
